// ----- hw/rtl/vrt_pkg.sv -----
package vrt_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;

	localparam logic [23:0] MAX_DIST_RST = 24'd524288;

	// result kinds
	localparam logic [1:0] KIND_QUERY = 2'd0;
	localparam logic [1:0] KIND_HIT   = 2'd1;
	localparam logic [1:0] KIND_MISS  = 2'd2;

	// entry faces
	localparam logic [2:0] FACE_NONE = 3'd6;

	// step sign codes
	localparam logic [1:0] SIGN_NONE = 2'd0;
	localparam logic [1:0] SIGN_POS  = 2'd1;
	localparam logic [1:0] SIGN_NEG  = 2'd3;

	// commands
	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_ANSWER = 1'b1;

endpackage

// ----- hw/rtl/voxel_ray_traversal_top.sv -----
// Channel | Direction | Handshake            | Beat carries
// in      | input     | in_valid / in_ready  | command, origin_x/y/z, dir_x/y/z, solid
// out     | output    | out_valid / out_ready| kind, voxel_x/y/z, prev_x/y/z, face, distance
// cfg     | input     | cfg_we (no wait)     | cfg_wdata = max_distance
//
// Answer beat: the result lands in the output register on the accept edge.
// Start beat: with a nonzero direction, setup runs on the shared 34-bit restoring
//   subtractor (32 root steps, up to six 64-step divides, two per nonzero axis).
//   A zero direction answers a miss on the accept edge.
// in_ready is high only when the sequencer is idle and the output register is free
//   or being drained, so a stalled output holds the next beat off.
// Reset clears control state and restores max_distance; no clearing pass.
module voxel_ray_traversal_top #(
	parameter int COORD_BITS = vrt_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = vrt_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	input  logic               solid,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic signed [15:0] voxel_x,
	output logic signed [15:0] voxel_y,
	output logic signed [15:0] voxel_z,
	output logic signed [15:0] prev_x,
	output logic signed [15:0] prev_y,
	output logic signed [15:0] prev_z,
	output logic [2:0]         face,
	output logic [23:0]        distance,
	input  logic               cfg_we,
	input  logic [23:0]        cfg_wdata
);

	localparam int CW = (COORD_BITS > 16) ? COORD_BITS : 16;
	localparam int MA = (FRAC_BITS + 1 > 16) ? FRAC_BITS + 1 : 16;

	// sequencer codes
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SQ    = 4'd1;
	localparam logic [3:0] ST_ACC   = 4'd2;
	localparam logic [3:0] ST_SQRT  = 4'd3;
	localparam logic [3:0] ST_AX    = 4'd4;
	localparam logic [3:0] ST_DIV   = 4'd5;
	localparam logic [3:0] ST_MULF  = 4'd6;
	localparam logic [3:0] ST_LOADD = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0]  state_q;
	logic [1:0]  ax_q;
	logic [5:0]  cnt_q;
	logic        divsel_q;
	logic        active_q;
	logic [23:0] max_dist_q;

	logic [COORD_BITS-1:0] cur_q  [3];
	logic [COORD_BITS-1:0] prev_q [3];
	logic [31:0]           nb_q   [3];
	logic [31:0]           sd_q   [3];
	logic [1:0]            sign_q [3];
	logic [15:0]           mag_q  [3];
	logic [FRAC_BITS-1:0]  frac_q [3];
	logic [31:0]           ray_dist_q;
	logic [2:0]            entry_face_q;

	logic [31:0] sum_q;
	logic [31:0] len_q;
	logic [63:0] prod_q;
	logic [63:0] shreg_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;

	// output register
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [CW-1:0] vox_q [3];
	logic [CW-1:0] prv_q [3];
	logic [2:0]  face_q;
	logic [23:0] dist_q;

	logic in_acc;
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_acc   = in_valid && in_ready;

	// start beat decode
	logic signed [31:0] org [3];
	logic [15:0]        dir [3];
	logic [15:0]        mag_in [3];
	logic               neg_in [3];
	logic signed [31:0] osh [3];
	assign org[0] = origin_x;
	assign org[1] = origin_y;
	assign org[2] = origin_z;
	assign dir[0] = dir_x;
	assign dir[1] = dir_y;
	assign dir[2] = dir_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg_in[i] = dir[i][15];
			mag_in[i] = neg_in[i] ? (16'd0 - dir[i]) : dir[i];
			osh[i]    = org[i] >>> FRAC_BITS;
		end
	end

	logic dir_zero;
	assign dir_zero = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);

	// current axis operands
	logic [15:0]          mag_ax;
	logic [FRAC_BITS-1:0] frac_ax;
	logic [1:0]           sign_ax;
	always_comb begin
		mag_ax  = mag_q[0];
		frac_ax = frac_q[0];
		sign_ax = sign_q[0];
		for (int i = 1; i < 3; i++) begin
			if (ax_q == 2'(i)) begin
				mag_ax  = mag_q[i];
				frac_ax = frac_q[i];
				sign_ax = sign_q[i];
			end
		end
	end

	// distance to first wall, Q.FRAC
	logic [FRAC_BITS:0] fd;
	assign fd = (sign_ax == vrt_pkg::SIGN_NEG) ? (FRAC_BITS+1)'(frac_ax)
		: ({1'b1, {FRAC_BITS{1'b0}}} - (FRAC_BITS+1)'(frac_ax));

	// shared multiplier
	logic [MA-1:0] mul_a;
	logic [31:0]   mul_b;
	logic [63:0]   mul_p;
	always_comb begin
		if (state_q == ST_MULF) begin
			mul_a = MA'(fd);
			mul_b = len_q;
		end else begin
			mul_a = MA'(mag_ax);
			mul_b = 32'(mag_ax);
		end
	end
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// shared restoring subtractor: root step or divide step
	logic [33:0] cand, trial;
	logic [34:0] diff;
	logic        ge;
	logic [31:0] den;
	assign den = {mag_ax, 16'd0};
	always_comb begin
		if (state_q == ST_SQRT) begin
			cand  = {rem_q[31:0], shreg_q[63:62]};
			trial = {root_q, 2'b01};
		end else begin
			cand  = {rem_q[32:0], shreg_q[63]};
			trial = 34'(den);
		end
	end
	assign diff = {1'b0, cand} - {1'b0, trial};
	assign ge   = !diff[34];

	logic [63:0] quot;
	logic [31:0] quot_sat;
	assign quot     = {shreg_q[62:0], ge};
	assign quot_sat = (|quot[63:32]) ? 32'hFFFF_FFFF : quot[31:0];

	logic [31:0] sum_next;
	assign sum_next = sum_q + prod_q[31:0];

	// answer step: nearest boundary, ties to x then y
	logic [1:0]  st_ax;
	logic [31:0] st_nb, st_sd, st_nb_new;
	logic [32:0] st_add;
	logic [1:0]  st_sign;
	logic [2:0]  st_face;
	logic [COORD_BITS-1:0] st_cell [3];
	always_comb begin
		if (nb_q[0] <= nb_q[1] && nb_q[0] <= nb_q[2]) st_ax = 2'd0;
		else if (nb_q[1] <= nb_q[2])                 st_ax = 2'd1;
		else                                          st_ax = 2'd2;
		st_nb   = nb_q[0];
		st_sd   = sd_q[0];
		st_sign = sign_q[0];
		for (int i = 1; i < 3; i++) begin
			if (st_ax == 2'(i)) begin
				st_nb   = nb_q[i];
				st_sd   = sd_q[i];
				st_sign = sign_q[i];
			end
		end
		st_add    = {1'b0, st_nb} + {1'b0, st_sd};
		st_nb_new = st_add[32] ? 32'hFFFF_FFFF : st_add[31:0];
		for (int i = 0; i < 3; i++) begin
			st_cell[i] = cur_q[i];
			if (st_ax == 2'(i)) begin
				if (st_sign == vrt_pkg::SIGN_POS)      st_cell[i] = cur_q[i] + 1'b1;
				else if (st_sign == vrt_pkg::SIGN_NEG) st_cell[i] = cur_q[i] - 1'b1;
			end
		end
		if (st_sign == vrt_pkg::SIGN_POS)      st_face = {st_ax, 1'b1};
		else if (st_sign == vrt_pkg::SIGN_NEG) st_face = {st_ax, 1'b0};
		else                                   st_face = vrt_pkg::FACE_NONE;
	end

	logic st_far;
	assign st_far = st_nb > 32'(max_dist_q);

	// a result beat is loaded: zero-direction miss, answer on a live ray, end of setup
	logic out_set;
	assign out_set = (state_q == ST_DONE)
		|| (in_acc && ((command == vrt_pkg::CMD_START) ? dir_zero : active_q));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ax_q        <= '0;
			cnt_q       <= '0;
			divsel_q    <= 1'b0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			max_dist_q  <= vrt_pkg::MAX_DIST_RST;
		end else begin
			if (cfg_we) max_dist_q <= cfg_wdata;
			out_valid_q <= out_set || (out_valid_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (command == vrt_pkg::CMD_START) begin
							active_q <= 1'b0;
							ax_q     <= '0;
							if (!dir_zero) state_q <= ST_SQ;
						end else if (active_q) begin
							if (solid || st_far) active_q <= 1'b0;
						end
					end
				end
				ST_SQ: state_q <= ST_ACC;
				ST_ACC: begin
					cnt_q <= '0;
					if (ax_q == 2'd2) begin
						state_q <= ST_SQRT;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= ST_SQ;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						ax_q    <= '0;
						state_q <= ST_AX;
					end
				end
				ST_AX: begin
					cnt_q    <= '0;
					divsel_q <= 1'b0;
					if (mag_ax != '0)       state_q <= ST_DIV;
					else if (ax_q == 2'd2)  state_q <= ST_DONE;
					else                    ax_q    <= ax_q + 2'd1;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						if (!divsel_q) begin
							state_q <= ST_MULF;
						end else if (ax_q == 2'd2) begin
							state_q <= ST_DONE;
						end else begin
							ax_q    <= ax_q + 2'd1;
							state_q <= ST_AX;
						end
					end
				end
				ST_MULF: state_q <= ST_LOADD;
				ST_LOADD: begin
					cnt_q    <= '0;
					divsel_q <= 1'b1;
					state_q  <= ST_DIV;
				end
				ST_DONE: begin
					active_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc && command == vrt_pkg::CMD_START) begin
					sum_q <= '0;
					for (int i = 0; i < 3; i++) begin
						mag_q[i]  <= mag_in[i];
						frac_q[i] <= org[i][FRAC_BITS-1:0];
						cur_q[i]  <= osh[i][COORD_BITS-1:0];
						prev_q[i] <= osh[i][COORD_BITS-1:0];
						sign_q[i] <= (mag_in[i] == '0) ? vrt_pkg::SIGN_NONE
							: (neg_in[i] ? vrt_pkg::SIGN_NEG : vrt_pkg::SIGN_POS);
					end
					kind_q <= vrt_pkg::KIND_MISS;
					face_q <= vrt_pkg::FACE_NONE;
					dist_q <= '0;
					for (int i = 0; i < 3; i++) begin
						vox_q[i] <= '0;
						prv_q[i] <= '0;
					end
				end else if (in_acc && active_q) begin
					if (solid) begin
						kind_q <= vrt_pkg::KIND_HIT;
						face_q <= entry_face_q;
						dist_q <= ray_dist_q[23:0];
						for (int i = 0; i < 3; i++) begin
							vox_q[i] <= CW'(cur_q[i]);
							prv_q[i] <= CW'(prev_q[i]);
						end
					end else begin
						ray_dist_q   <= st_nb;
						entry_face_q <= st_face;
						for (int i = 0; i < 3; i++) begin
							prev_q[i] <= cur_q[i];
							cur_q[i]  <= st_cell[i];
							if (st_ax == 2'(i)) nb_q[i] <= st_nb_new;
						end
						kind_q <= st_far ? vrt_pkg::KIND_MISS : vrt_pkg::KIND_QUERY;
						face_q <= vrt_pkg::FACE_NONE;
						dist_q <= '0;
						for (int i = 0; i < 3; i++) begin
							vox_q[i] <= st_far ? '0 : CW'(st_cell[i]);
							prv_q[i] <= '0;
						end
					end
				end
			end
			ST_SQ: prod_q <= mul_p;
			ST_ACC: begin
				sum_q   <= sum_next;
				shreg_q <= {sum_next, 32'd0};
				rem_q   <= '0;
				root_q  <= '0;
			end
			ST_SQRT: begin
				rem_q   <= ge ? diff[33:0] : cand;
				root_q  <= {root_q[30:0], ge};
				shreg_q <= {shreg_q[61:0], 2'b00};
				if (cnt_q == 6'd31) len_q <= {root_q[30:0], ge};
			end
			ST_AX: begin
				rem_q   <= '0;
				shreg_q <= 64'(len_q) << FRAC_BITS;
				if (mag_ax == '0) begin
					for (int i = 0; i < 3; i++) begin
						if (ax_q == 2'(i)) begin
							nb_q[i] <= 32'hFFFF_FFFF;
							sd_q[i] <= 32'hFFFF_FFFF;
						end
					end
				end
			end
			ST_DIV: begin
				rem_q   <= ge ? diff[33:0] : cand;
				shreg_q <= quot;
				if (cnt_q == 6'd63) begin
					for (int i = 0; i < 3; i++) begin
						if (ax_q == 2'(i)) begin
							if (divsel_q) nb_q[i] <= quot_sat;
							else          sd_q[i] <= quot_sat;
						end
					end
				end
			end
			ST_MULF: prod_q <= mul_p;
			ST_LOADD: begin
				shreg_q <= prod_q;
				rem_q   <= '0;
			end
			ST_DONE: begin
				ray_dist_q   <= '0;
				entry_face_q <= vrt_pkg::FACE_NONE;
				kind_q       <= vrt_pkg::KIND_QUERY;
				face_q       <= vrt_pkg::FACE_NONE;
				dist_q       <= '0;
				for (int i = 0; i < 3; i++) begin
					vox_q[i] <= CW'(cur_q[i]);
					prv_q[i] <= '0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign voxel_x   = vox_q[0][15:0];
	assign voxel_y   = vox_q[1][15:0];
	assign voxel_z   = vox_q[2][15:0];
	assign prev_x    = prv_q[0][15:0];
	assign prev_y    = prv_q[1][15:0];
	assign prev_z    = prv_q[2][15:0];
	assign face      = face_q;
	assign distance  = dist_q;

	// checks
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == ST_IDLE))
		else $error("in_ready outside idle");

	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == vrt_pkg::KIND_MISS) |-> (face_q == vrt_pkg::FACE_NONE
		&& dist_q == '0))
		else $error("miss carries face or distance");

	a_setup_query: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> (active_q && out_valid_q
		&& kind_q == vrt_pkg::KIND_QUERY))
		else $error("setup end without query");

	a_hit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid_q) && kind_q != vrt_pkg::KIND_QUERY) |-> !active_q)
		else $error("ray still active after hit or miss");

endmodule
